// ----- hw/rtl/aoc_pkg.sv -----
// aoc_pkg: shared types and constants for the alpha-over compositor.
// No dependencies; used by aoc_prep, aoc_div_step and the top level.
package aoc_pkg;

  localparam int unsigned NUM_CH   = 3;
  localparam int unsigned PIX_W    = 8;
  localparam int unsigned NUM_W    = 25;  // tc*ta*255 + bc*ba*(255-ta) < 2^25
  localparam int unsigned DEN_W    = 16;  // oa*255 < 2^16
  localparam int unsigned DIV_BITS = 2;   // quotient bits resolved per divider stage
  localparam int unsigned DIV_STGS = PIX_W / DIV_BITS;

  localparam logic [PIX_W-1:0] MAX_VAL = 8'd255;

  // floor(x/255) == (x*RECIP) >> RECIP_SHIFT for any 16-bit x
  localparam logic [15:0]  RECIP       = 16'd32897;
  localparam int unsigned  RECIP_SHIFT = 23;

  localparam int unsigned CH_RED   = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE  = 2;

  typedef struct packed {
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
    logic [PIX_W-1:0] a;
  } aoc_pix_t;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [PIX_W-1:0] quo;
  } aoc_chan_t;

  typedef struct packed {
    aoc_chan_t [NUM_CH-1:0] ch;
    logic [DEN_W-1:0]       den;
    logic [PIX_W-1:0]       alpha;
  } aoc_div_t;

endpackage

// ----- hw/rtl/aoc_prep.sv -----
// aoc_prep: three front stages - products, numerators and alpha, divider setup.
// Depends on aoc_pkg.
module aoc_prep (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  aoc_pkg::aoc_pix_t top_pix,
  input  aoc_pkg::aoc_pix_t bot_pix,
  input  logic             below,
  output logic             dn_valid,
  input  logic             dn_ready,
  output aoc_pkg::aoc_div_t dn_data
);

  // ---- stage 1: 8x8 products and copy/blend decision
  logic        p1_v_r, p1_rdy;
  logic [15:0] tcta_r [aoc_pkg::NUM_CH];
  logic [15:0] bcba_r [aoc_pkg::NUM_CH];
  logic [15:0] aprod_r;
  logic [7:0]  ta_r, inv_r;
  logic        byp_r;
  aoc_pkg::aoc_pix_t bpix_r;

  logic [7:0]  tc [aoc_pkg::NUM_CH];
  logic [7:0]  bc [aoc_pkg::NUM_CH];
  logic [7:0]  inv_nxt;
  logic        byp_nxt;
  aoc_pkg::aoc_pix_t bpix_nxt;

  // ---- stage 2
  logic        p2_v_r, p2_rdy;
  logic [aoc_pkg::NUM_W-1:0] num_r [aoc_pkg::NUM_CH];
  logic [7:0]  oa_r;
  logic        byp2_r;
  aoc_pkg::aoc_pix_t bpix2_r;
  logic [31:0] recip_prod;
  logic [7:0]  oa_nxt;
  logic [aoc_pkg::NUM_W-1:0] num_nxt [aoc_pkg::NUM_CH];

  // ---- stage 3
  logic        p3_v_r, p3_rdy;
  aoc_pkg::aoc_div_t dv_r, dv_nxt;
  logic [aoc_pkg::DEN_W-1:0] den;
  logic [7:0]  bvals [aoc_pkg::NUM_CH];

  assign tc[aoc_pkg::CH_RED]   = top_pix.r;
  assign tc[aoc_pkg::CH_GREEN] = top_pix.g;
  assign tc[aoc_pkg::CH_BLUE]  = top_pix.b;
  assign bc[aoc_pkg::CH_RED]   = bot_pix.r;
  assign bc[aoc_pkg::CH_GREEN] = bot_pix.g;
  assign bc[aoc_pkg::CH_BLUE]  = bot_pix.b;

  assign inv_nxt = aoc_pkg::MAX_VAL - top_pix.a;

  always_comb begin
    byp_nxt  = 1'b0;
    bpix_nxt = top_pix;
    if (top_pix.a == aoc_pkg::MAX_VAL || bot_pix.a == 8'd0) begin
      byp_nxt  = 1'b1;
      bpix_nxt = (below && top_pix.a == 8'd0) ? bot_pix : top_pix;
    end else if (top_pix.a == 8'd0) begin
      byp_nxt  = 1'b1;
      bpix_nxt = bot_pix;
    end
  end

  assign p1_rdy   = !p1_v_r || p2_rdy;
  assign up_ready = p1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (p1_rdy) begin
      p1_v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_rdy && up_valid) begin
      for (int k = 0; k < aoc_pkg::NUM_CH; k++) begin
        tcta_r[k] <= 16'(tc[k]) * 16'(top_pix.a);
        bcba_r[k] <= 16'(bc[k]) * 16'(bot_pix.a);
      end
      aprod_r <= 16'(bot_pix.a) * 16'(inv_nxt);
      ta_r    <= top_pix.a;
      inv_r   <= inv_nxt;
      byp_r   <= byp_nxt;
      bpix_r  <= bpix_nxt;
    end
  end

  // ---- stage 2: numerators, out alpha via reciprocal of 255
  assign recip_prod = 32'(aprod_r) * 32'(aoc_pkg::RECIP);
  assign oa_nxt = ta_r + recip_prod[aoc_pkg::RECIP_SHIFT +: 8];

  always_comb begin
    for (int k = 0; k < aoc_pkg::NUM_CH; k++) begin
      num_nxt[k] = aoc_pkg::NUM_W'({tcta_r[k], 8'd0}) - aoc_pkg::NUM_W'(tcta_r[k])
                 + aoc_pkg::NUM_W'(24'(bcba_r[k]) * 24'(inv_r));
    end
  end

  assign p2_rdy = !p2_v_r || p3_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
    end else if (p2_rdy) begin
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p2_rdy && p1_v_r) begin
      num_r   <= num_nxt;
      oa_r    <= oa_nxt;
      byp2_r  <= byp_r;
      bpix2_r <= bpix_r;
    end
  end

  // ---- stage 3: denominator, saturation, copy preload
  assign den = {oa_r, 8'd0} - {8'd0, oa_r};
  assign bvals[aoc_pkg::CH_RED]   = bpix2_r.r;
  assign bvals[aoc_pkg::CH_GREEN] = bpix2_r.g;
  assign bvals[aoc_pkg::CH_BLUE]  = bpix2_r.b;

  always_comb begin
    dv_nxt.den   = den;
    dv_nxt.alpha = oa_r;
    for (int k = 0; k < aoc_pkg::NUM_CH; k++) begin
      dv_nxt.ch[k].rem = num_r[k];
      dv_nxt.ch[k].quo = 8'd0;
      if (num_r[k] >= aoc_pkg::NUM_W'({den, 8'd0})) begin
        // quotient would pass 255: clamp, nothing left to divide
        dv_nxt.ch[k].rem = '0;
        dv_nxt.ch[k].quo = aoc_pkg::MAX_VAL;
      end
    end
    if (byp2_r) begin
      // copy: result preloaded, zero remainder keeps divider steps idle
      dv_nxt.den   = aoc_pkg::DEN_W'(1);
      dv_nxt.alpha = bpix2_r.a;
      for (int k = 0; k < aoc_pkg::NUM_CH; k++) begin
        dv_nxt.ch[k].rem = '0;
        dv_nxt.ch[k].quo = bvals[k];
      end
    end
  end

  assign p3_rdy = !p3_v_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_v_r <= 1'b0;
    end else if (p3_rdy) begin
      p3_v_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p3_rdy && p2_v_r) begin
      dv_r <= dv_nxt;
    end
  end

  assign dn_valid = p3_v_r;
  assign dn_data  = dv_r;

endmodule

// ----- hw/rtl/aoc_div_step.sv -----
// aoc_div_step: one restoring-division stage, two quotient bits for all channels.
// Depends on aoc_pkg.
module aoc_div_step #(
  parameter int unsigned BIT_HI = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  aoc_pkg::aoc_div_t up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output aoc_pkg::aoc_div_t dn_data
);

  localparam int unsigned BIT_LO = BIT_HI - 1;

  logic              v_r;
  aoc_pkg::aoc_div_t d_r, d_nxt;

  always_comb begin
    logic [aoc_pkg::NUM_W:0]   trial;
    logic [aoc_pkg::NUM_W-1:0] dext;
    dext  = aoc_pkg::NUM_W'(up_data.den);
    d_nxt = up_data;
    for (int k = 0; k < aoc_pkg::NUM_CH; k++) begin
      trial = {1'b0, d_nxt.ch[k].rem} - {1'b0, dext << BIT_HI};
      if (!trial[aoc_pkg::NUM_W]) begin
        d_nxt.ch[k].rem         = trial[aoc_pkg::NUM_W-1:0];
        d_nxt.ch[k].quo[BIT_HI] = 1'b1;
      end
      trial = {1'b0, d_nxt.ch[k].rem} - {1'b0, dext << BIT_LO};
      if (!trial[aoc_pkg::NUM_W]) begin
        d_nxt.ch[k].rem         = trial[aoc_pkg::NUM_W-1:0];
        d_nxt.ch[k].quo[BIT_LO] = 1'b1;
      end
    end
  end

  assign up_ready = !v_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      d_r <= d_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_data  = d_r;

endmodule

// ----- hw/rtl/alpha_over_compositor_unit.sv -----
// alpha_over_compositor_unit: top level, Porter-Duff over blend of RGBA8 pixels.
// Depends on aoc_pkg, aoc_prep and aoc_div_step.

// Takes one top/bottom pixel pair per cycle and returns one blended pixel per
// pair, in order. Seven register stages: the first loads at the accepting edge
// and the last one drives the out_ port. The stages are three front stages (8x8
// products; numerators and out alpha via a reciprocal multiply; denominator
// and clamp), then four restoring-division stages of two quotient bits each.
// Every stage carries its own valid bit and is refilled as soon as its beat
// moves on, so a held-off output only backs up as far as there are full stages
// and in_ready stays high while any stage is empty. Copy cases (opaque or
// transparent pixels) travel the same pipe with the result preloaded, so
// order is kept. Sustained rate is one beat per clock with out_ready high.
module alpha_over_compositor_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_top_red,
  input  logic [7:0] in_top_green,
  input  logic [7:0] in_top_blue,
  input  logic [7:0] in_top_alpha,
  input  logic [7:0] in_bottom_red,
  input  logic [7:0] in_bottom_green,
  input  logic [7:0] in_bottom_blue,
  input  logic [7:0] in_bottom_alpha,
  input  logic       in_store_below,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha
);

  aoc_pkg::aoc_pix_t top_pix, bot_pix;

  // index 0 is the front end output, last index feeds the out_ port
  logic              stg_valid [aoc_pkg::DIV_STGS+1];
  logic              stg_ready [aoc_pkg::DIV_STGS+1];
  aoc_pkg::aoc_div_t stg_data  [aoc_pkg::DIV_STGS+1];

  assign top_pix = '{r: in_top_red, g: in_top_green, b: in_top_blue, a: in_top_alpha};
  assign bot_pix = '{r: in_bottom_red, g: in_bottom_green, b: in_bottom_blue,
                     a: in_bottom_alpha};

  aoc_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .top_pix  (top_pix),
    .bot_pix  (bot_pix),
    .below    (in_store_below),
    .dn_valid (stg_valid[0]),
    .dn_ready (stg_ready[0]),
    .dn_data  (stg_data[0])
  );

  // quotient bits 7..0, two per stage, most significant first
  for (genvar j = 0; j < aoc_pkg::DIV_STGS; j++) begin : g_div
    aoc_div_step #(
      .BIT_HI (aoc_pkg::PIX_W - 1 - aoc_pkg::DIV_BITS * j)
    ) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stg_valid[j]),
      .up_ready (stg_ready[j]),
      .up_data  (stg_data[j]),
      .dn_valid (stg_valid[j+1]),
      .dn_ready (stg_ready[j+1]),
      .dn_data  (stg_data[j+1])
    );
  end

  // last divider register doubles as the output register
  assign out_valid = stg_valid[aoc_pkg::DIV_STGS];
  assign stg_ready[aoc_pkg::DIV_STGS] = out_ready;
  assign out_red   = stg_data[aoc_pkg::DIV_STGS].ch[aoc_pkg::CH_RED].quo;
  assign out_green = stg_data[aoc_pkg::DIV_STGS].ch[aoc_pkg::CH_GREEN].quo;
  assign out_blue  = stg_data[aoc_pkg::DIV_STGS].ch[aoc_pkg::CH_BLUE].quo;
  assign out_alpha = stg_data[aoc_pkg::DIV_STGS].alpha;

  // empty output stage means the whole ready chain is open
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low with output stage empty");

  // divider never sees a zero denominator
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    stg_valid[0] |-> stg_data[0].den != '0)
    else $error("zero denominator entering divider");

  // setup leaves each remainder below den*256, so eight bits suffice
  a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    stg_valid[0] |->
      (stg_data[0].ch[aoc_pkg::CH_RED].rem   < aoc_pkg::NUM_W'({stg_data[0].den, 8'd0})) &&
      (stg_data[0].ch[aoc_pkg::CH_GREEN].rem < aoc_pkg::NUM_W'({stg_data[0].den, 8'd0})) &&
      (stg_data[0].ch[aoc_pkg::CH_BLUE].rem  < aoc_pkg::NUM_W'({stg_data[0].den, 8'd0})))
    else $error("divider remainder out of range at setup");

  // after the last step every remainder is below the divisor
  a_rem_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (stg_data[aoc_pkg::DIV_STGS].ch[aoc_pkg::CH_RED].rem
         < aoc_pkg::NUM_W'(stg_data[aoc_pkg::DIV_STGS].den)) &&
      (stg_data[aoc_pkg::DIV_STGS].ch[aoc_pkg::CH_GREEN].rem
         < aoc_pkg::NUM_W'(stg_data[aoc_pkg::DIV_STGS].den)) &&
      (stg_data[aoc_pkg::DIV_STGS].ch[aoc_pkg::CH_BLUE].rem
         < aoc_pkg::NUM_W'(stg_data[aoc_pkg::DIV_STGS].den)))
    else $error("division incomplete at output");

endmodule
